>>> src/ibc_pkg.sv
package ibc_pkg;

  // Six axes in the order accel x, y, z, then rate x, y, z.
  localparam int AXES = 6;
  localparam int DATA_W = 16;
  localparam int GRAV_W = 15;

  localparam int AXIS_ACCEL_Z = 2;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd8192;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [AXES-1:0][DATA_W-1:0] axes_t;

  // Command from the top level to the offset divider.
  typedef struct packed {
    logic              start;
    logic [GRAV_W-1:0] gravity;
  } div_cmd_t;

  // Status from the offset divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> src/ibc_in_if.sv
interface ibc_in_if;
  import ibc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t rate_x;
  sample_t rate_y;
  sample_t rate_z;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    input  ready
  );

  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    output ready
  );

endinterface

>>> src/ibc_out_if.sv
interface ibc_out_if;
  import ibc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t accel_x_corr;
  sample_t accel_y_corr;
  sample_t accel_z_corr;
  sample_t rate_x_corr;
  sample_t rate_y_corr;
  sample_t rate_z_corr;

  modport source (
    output valid, accel_x_corr, accel_y_corr, accel_z_corr,
           rate_x_corr, rate_y_corr, rate_z_corr,
    input  ready
  );

  modport sink (
    input  valid, accel_x_corr, accel_y_corr, accel_z_corr,
           rate_x_corr, rate_y_corr, rate_z_corr,
    output ready
  );

endinterface

>>> src/ibc_accum.sv
module ibc_accum #(
  parameter int SAMPLES = 128,
  parameter int SUM_W   = 24,
  parameter int CNT_W   = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  ibc_pkg::axes_t                           samples,
  output logic                                     last,
  output logic [ibc_pkg::AXES-1:0][SUM_W-1:0]      sums
);
  import ibc_pkg::*;

  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [AXES-1:0][SUM_W-1:0]  sums_r;
  logic [AXES-1:0][SUM_W-1:0]  sums_nxt;

  // The word that brings the count to SAMPLES closes calibration.
  assign last = en && (count_r == CNT_W'(SAMPLES - 1));

  // One sign-extending add per axis.
  always_comb begin
    count_nxt = count_r;
    sums_nxt  = sums_r;
    if (en) begin
      count_nxt = count_r + CNT_W'(1);
      for (int i = 0; i < AXES; i++) begin
        sums_nxt[i] = sums_r[i] +
          {{(SUM_W - DATA_W){samples[i][DATA_W-1]}}, samples[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sums_r  <= '0;
    end else begin
      count_r <= count_nxt;
      sums_r  <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

>>> src/ibc_div.sv
module ibc_div #(
  parameter int SAMPLES = 128,
  parameter int SUM_W   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ibc_pkg::div_cmd_t                     cmd,
  input  logic [ibc_pkg::AXES-1:0][SUM_W-1:0]   sums,
  output ibc_pkg::div_sts_t                     sts,
  output ibc_pkg::axes_t                        offsets
);
  import ibc_pkg::*;

  // A sum magnitude stays below 2**(SUM_W-1). Multiplying it by the rounded-up
  // reciprocal of SAMPLES and dropping SHIFT bits gives the exact quotient.
  localparam int MAG_W  = SUM_W - 1;
  localparam int SHIFT  = MAG_W + $clog2(SAMPLES);
  localparam int PROD_W = MAG_W + SUM_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [SUM_W-1:0] RECIP = RECIP_WIDE[SUM_W-1:0];

  logic [AXES-1:0][SUM_W-1:0]   mag_in;
  logic [AXES-1:0][MAG_W-1:0]   mag_r;
  logic [AXES-1:0]              neg_r;
  logic [AXES-1:0][DATA_W-1:0]  quo_r;
  logic [AXES-1:0][DATA_W-1:0]  quo_nxt;
  logic [PROD_W-1:0]            prod;
  logic                         mul_r;
  logic                         fin_r;
  logic                         done_r;
  logic [GRAV_W-1:0]            grav_r;
  axes_t                        offsets_r;
  axes_t                        offsets_nxt;

  // Magnitude of each sum; the sign is kept aside.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mag_in[i] = sums[i][SUM_W-1] ? (~sums[i] + SUM_W'(1)) : sums[i];
    end
  end

  // One reciprocal multiply per axis gives the truncated quotient.
  always_comb begin
    prod = '0;
    for (int i = 0; i < AXES; i++) begin
      prod = PROD_W'(mag_r[i]) * PROD_W'(RECIP);
      quo_nxt[i] = prod[SHIFT +: DATA_W];
    end
  end

  // Restore the sign (truncation toward zero) and take gravity off accel z.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      offsets_nxt[i] = neg_r[i] ? (~quo_r[i] + DATA_W'(1)) : quo_r[i];
      if (i == AXIS_ACCEL_Z) begin
        offsets_nxt[i] = offsets_nxt[i] - {1'b0, grav_r};
      end
    end
  end

  // Three steps: load magnitudes, multiply, then sign and gravity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r     <= 1'b0;
      fin_r     <= 1'b0;
      done_r    <= 1'b0;
      offsets_r <= '0;
    end else begin
      mul_r  <= cmd.start;
      fin_r  <= mul_r;
      done_r <= fin_r;
      if (fin_r) begin
        offsets_r <= offsets_nxt;
      end
    end
  end

  // Datapath registers of the lanes.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      grav_r <= cmd.gravity;
      for (int i = 0; i < AXES; i++) begin
        neg_r[i] <= sums[i][SUM_W-1];
        mag_r[i] <= mag_in[i][MAG_W-1:0];
      end
    end
    if (mul_r) begin
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = mul_r || fin_r;
  assign sts.done = done_r;
  assign offsets  = offsets_r;

endmodule

>>> src/ibc_corr.sv
module ibc_corr (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take_valid,
  output logic           take_ready,
  input  ibc_pkg::axes_t samples,
  input  ibc_pkg::axes_t offsets,
  output logic           out_valid,
  input  logic           out_ready,
  output ibc_pkg::axes_t out_data
);
  import ibc_pkg::*;

  logic  s1_v_r;
  logic  s1_v_nxt;
  axes_t s1_data_r;
  logic  out_v_r;
  axes_t out_data_r;
  axes_t diff;
  logic  out_adv;
  logic  s1_ready;

  // Each stage moves when the one after it is empty or draining.
  assign out_adv    = !out_v_r || out_ready;
  assign s1_ready   = !s1_v_r || out_adv;
  assign take_ready = s1_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (take_valid && s1_ready) begin
      s1_v_nxt = 1'b1;
    end else if (out_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  // Subtract the offsets, wrapping to 16 bits.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = s1_data_r[i] - offsets[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_valid && s1_ready) begin
      s1_data_r <= samples;
    end
    if (out_adv && s1_v_r) begin
      out_data_r <= diff;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

>>> src/imu_bias_calibrate_and_correct.sv
// Channel   Dir  Handshake            Word
// in_ch     in   valid/ready          six raw axes, 16-bit signed each
// out_ch    out  valid/ready          six corrected axes, 16-bit signed each
// cfg       in   cfg_we/cfg_wdata     gravity_counts, 15 bits
//
// The first SAMPLES words are accumulated at one per cycle and give no result.
// The offsets are then computed with in_ch.ready low: magnitude load, one
// reciprocal multiply per axis, sign and gravity, and the handoff.
// After that one word is taken every cycle while out_ch does not stall; each word is registered twice on its way.
// Reset is synchronous and active low; out_ch stalls back up through both stages.
module imu_bias_calibrate_and_correct #(
  parameter int SAMPLES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ibc_in_if.sink                        in_ch,
  ibc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ibc_pkg::GRAV_W-1:0]    cfg_wdata
);
  import ibc_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = DATA_W + $clog2(SAMPLES + 1);

  logic                        calibrating_r;
  logic                        offsets_ok_r;
  logic                        start_r;
  logic [GRAV_W-1:0]           gravity_r;
  logic [GRAV_W-1:0]           grav_snap_r;
  logic                        in_fire;
  logic                        acc_en;
  logic                        acc_last;
  logic [AXES-1:0][SUM_W-1:0]  sums;
  div_cmd_t                    div_cmd;
  div_sts_t                    div_sts;
  axes_t                       offsets;
  axes_t                       samples;
  axes_t                       corr_data;
  logic                        corr_take;
  logic                        corr_ready;

  assign samples = {in_ch.rate_z, in_ch.rate_y, in_ch.rate_x,
                    in_ch.accel_z, in_ch.accel_y, in_ch.accel_x};

  // While calibrating every word goes to the accumulator; afterward the
  // correction pipeline takes words once the offsets are in place.
  assign in_ch.ready = calibrating_r || (offsets_ok_r && corr_ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign acc_en      = in_fire && calibrating_r;
  assign corr_take   = in_ch.valid && offsets_ok_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAV_RESET;
    end else if (cfg_we) begin
      gravity_r <= cfg_wdata;
    end
  end

  // Calibration phase control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrating_r <= 1'b1;
      offsets_ok_r  <= 1'b0;
      start_r       <= 1'b0;
    end else begin
      start_r <= acc_last;
      if (acc_last) begin
        calibrating_r <= 1'b0;
      end
      if (div_sts.done) begin
        offsets_ok_r <= 1'b1;
      end
    end
  end

  // Gravity is sampled when the last calibration word arrives.
  always_ff @(posedge clk) begin
    if (acc_last) begin
      grav_snap_r <= gravity_r;
    end
  end

  assign div_cmd.start   = start_r;
  assign div_cmd.gravity = grav_snap_r;

  ibc_accum #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W),
    .CNT_W   (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc_en),
    .samples (samples),
    .last    (acc_last),
    .sums    (sums)
  );

  ibc_div #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (div_cmd),
    .sums    (sums),
    .sts     (div_sts),
    .offsets (offsets)
  );

  ibc_corr u_corr (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_valid (corr_take),
    .take_ready (corr_ready),
    .samples    (samples),
    .offsets    (offsets),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (corr_data)
  );

  assign out_ch.accel_x_corr = corr_data[0];
  assign out_ch.accel_y_corr = corr_data[1];
  assign out_ch.accel_z_corr = corr_data[2];
  assign out_ch.rate_x_corr  = corr_data[3];
  assign out_ch.rate_y_corr  = corr_data[4];
  assign out_ch.rate_z_corr  = corr_data[5];

  // No word is taken while the offsets are being computed.
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (!calibrating_r && !offsets_ok_r) |-> !in_ch.ready)
    else $error("word accepted while offsets were being computed");

  // No result leaves before calibration has finished.
  a_no_result_while_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
    calibrating_r |-> !out_ch.valid)
    else $error("result produced during calibration");

  // The divider finishes only once, after calibration ends.
  a_done_after_calibration: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (!calibrating_r && !offsets_ok_r))
    else $error("divider finished outside the offset phase");

  // Calibration ends by starting the divider on the next cycle.
  a_start_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc_last |=> (div_cmd.start && !calibrating_r))
    else $error("divider not started after the last calibration word");

endmodule
